### hw/rtl/trpd_pkg.sv
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trpd_pkg;

    // Result kind, travels on the result channel tuser
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // Header byte positions
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_TYPE      = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;

    // Accepted formats
    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] TYPE_RLE       = 8'd10;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;

    // Descriptor origin bit and packet run flag
    localparam int DESC_ORIGIN_BIT = 5;
    localparam int PKT_RUN_BIT     = 7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // One result transaction
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_res;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic        top_origin;
        logic        last_pixel;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/tga_rle_pixel_decoder.sv
// A result is registered in the output or skid stage before the m_ side shows it.
// Throughput: one file byte per cycle while s_tready is high; at most one result per byte.
// s_tready drops only while the skid stage holds a result behind a stalled output.
// Reset: aresetn (synchronous, active low) clears all parse state and the valid
// flags of both output stages; no clearing pass, the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Parses a TGA byte stream and emits header, error and RGBA pixel-run results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] first_byte
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [79:0] m_tdata,   // red, green, blue, alpha, repeat_res,
                                        // frame_width, frame_height, top_origin, zero pad
    output      logic [1:0]  m_tuser,   // [1:0] kind
    output      logic        m_tlast    // last_pixel
);

    logic              in_valid;
    logic              res_valid;
    trpd_pkg::result_t res;
    trpd_pkg::result_t out_res;
    logic              space;

    assign s_tready = space;
    assign in_valid = s_tvalid && space;

    // Parse and decode each accepted transaction
    trpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_byte   (s_tdata),
        .in_first  (s_tuser),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold results for the downstream side
    trpd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_data  (res),
        .space      (space),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (out_res)
    );

    // Pack result fields
    assign m_tdata = {7'd0, out_res.top_origin, out_res.frame_height, out_res.frame_width,
                      out_res.repeat_res, out_res.alpha, out_res.blue, out_res.green,
                      out_res.red};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_pixel;

endmodule

`default_nettype wire

### hw/rtl/trpd_parser.sv
// ----------------------------------------------------------------------------
// trpd_parser
// Header parse, ID skip and pixel/packet decode, one file byte per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trpd_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_first,
    output      logic              res_valid,
    output      trpd_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_PKTHDR = 3'd2,
        PH_RUNPIX = 3'd3,
        PH_RAWPIX = 3'd4,
        PH_PLAIN  = 3'd5,
        PH_IDLE   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next, ph;
    logic [4:0]  header_count_reg, header_count_next, hc;
    logic [7:0]  id_skip_left_reg, id_skip_left_next, id_cur;
    logic [7:0]  image_kind_reg, image_kind_next, kind_cur;
    logic [15:0] width_reg, width_next, width_cur;
    logic [15:0] height_reg, height_next, height_cur;
    logic [7:0]  depth_reg, depth_next, depth_cur;
    logic        four_comp_reg, four_comp_next, four_cur;
    logic        origin_reg, origin_next, origin_cur;
    logic [31:0] pixels_left_reg, pixels_left_next, pixels_cur;
    logic [7:0]  packet_left_reg, packet_left_next, packet_cur;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next, bip;
    logic [31:0] pixel_asm_reg, pixel_asm_next, asm_new;

    logic [31:0] area;
    logic        pix_done;
    logic [7:0]  run_count;
    logic [7:0]  emit_count;
    logic [31:0] pixels_after;
    logic        emit_last;
    logic [7:0]  raw_left;
    logic        fmt_ok;
    logic        emit;
    logic        hdr_done;
    logic        fmt_err;
    phase_t      enter_phase;

    // Image area, loaded into the pixel counter at the end of the header
    assign area = 32'(width_reg) * 32'(height_reg);

    // Restart from cleared state when the byte opens a new file
    always_comb begin
        ph         = in_first ? PH_HEADER : phase_reg;
        hc         = in_first ? 5'd0 : header_count_reg;
        id_cur     = in_first ? 8'd0 : id_skip_left_reg;
        kind_cur   = in_first ? 8'd0 : image_kind_reg;
        width_cur  = in_first ? 16'd0 : width_reg;
        height_cur = in_first ? 16'd0 : height_reg;
        depth_cur  = in_first ? 8'd0 : depth_reg;
        four_cur   = in_first ? 1'b0 : four_comp_reg;
        origin_cur = in_first ? 1'b0 : origin_reg;
        pixels_cur = in_first ? 32'd0 : pixels_left_reg;
        packet_cur = in_first ? 8'd0 : packet_left_reg;
        bip        = in_first ? 2'd0 : byte_in_pixel_reg;
    end

    // Pixel byte assembly and run clipping
    always_comb begin
        asm_new = pixel_asm_reg;
        asm_new[{bip, 3'b000} +: 8] = in_byte;
        pix_done     = (bip == 2'd3) || (!four_cur && (bip == 2'd2));
        run_count    = (ph == PH_RUNPIX) ? packet_cur : 8'd1;
        emit_count   = (32'(run_count) > pixels_cur) ? pixels_cur[7:0] : run_count;
        pixels_after = pixels_cur - 32'(emit_count);
        emit_last    = (pixels_after == 32'd0);
        raw_left     = packet_cur - 8'd1;
        fmt_ok       = ((depth_cur == trpd_pkg::DEPTH_24) || (depth_cur == trpd_pkg::DEPTH_32))
                    && ((kind_cur == trpd_pkg::TYPE_TRUECOLOR)
                     || (kind_cur == trpd_pkg::TYPE_RLE));
        enter_phase  = (kind_cur == trpd_pkg::TYPE_RLE) ? PH_PKTHDR : PH_PLAIN;
    end

    // Next state per phase
    always_comb begin
        phase_next         = ph;
        header_count_next  = hc;
        id_skip_left_next  = id_cur;
        image_kind_next    = kind_cur;
        width_next         = width_cur;
        height_next        = height_cur;
        depth_next         = depth_cur;
        four_comp_next     = four_cur;
        origin_next        = origin_cur;
        pixels_left_next   = pixels_cur;
        packet_left_next   = packet_cur;
        byte_in_pixel_next = bip;
        pixel_asm_next     = pixel_asm_reg;
        emit               = 1'b0;
        hdr_done           = 1'b0;
        fmt_err            = 1'b0;

        unique case (ph) inside
            PH_HEADER: begin
                case (hc)
                    trpd_pkg::HDR_ID_LEN:    id_skip_left_next = in_byte;
                    trpd_pkg::HDR_TYPE:      image_kind_next = in_byte;
                    trpd_pkg::HDR_WIDTH_LO:  width_next[7:0] = in_byte;
                    trpd_pkg::HDR_WIDTH_HI:  width_next[15:8] = in_byte;
                    trpd_pkg::HDR_HEIGHT_LO: height_next[7:0] = in_byte;
                    trpd_pkg::HDR_HEIGHT_HI: height_next[15:8] = in_byte;
                    trpd_pkg::HDR_DEPTH:     depth_next = in_byte;
                    trpd_pkg::HDR_DESC:
                        origin_next = in_byte[trpd_pkg::DESC_ORIGIN_BIT];
                    default: ;
                endcase
                if (hc < trpd_pkg::HDR_DESC) begin
                    header_count_next = hc + 5'd1;
                end else begin
                    header_count_next = 5'd0;
                    if (!fmt_ok) begin
                        fmt_err    = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        hdr_done           = 1'b1;
                        four_comp_next     = (depth_cur == trpd_pkg::DEPTH_32);
                        pixels_left_next   = area;
                        byte_in_pixel_next = 2'd0;
                        if (id_cur != 8'd0) begin
                            phase_next = PH_IDSKIP;
                        end else if ((width_cur == 16'd0) || (height_cur == 16'd0)) begin
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = enter_phase;
                        end
                    end
                end
            end
            PH_IDSKIP: begin
                id_skip_left_next = id_cur - 8'd1;
                if (id_skip_left_next == 8'd0) begin
                    phase_next = (pixels_cur == 32'd0) ? PH_IDLE : enter_phase;
                end
            end
            PH_PKTHDR: begin
                packet_left_next   = {1'b0, in_byte[6:0]} + 8'd1;
                byte_in_pixel_next = 2'd0;
                phase_next = in_byte[trpd_pkg::PKT_RUN_BIT] ? PH_RUNPIX : PH_RAWPIX;
            end
            PH_RUNPIX, PH_RAWPIX, PH_PLAIN: begin
                pixel_asm_next     = asm_new;
                byte_in_pixel_next = bip + 2'd1;
                if (pix_done) begin
                    emit = 1'b1;
                    if (ph == PH_RUNPIX) begin
                        phase_next = PH_PKTHDR;
                    end else if (ph == PH_RAWPIX) begin
                        packet_left_next = raw_left;
                        if (raw_left == 8'd0) begin
                            phase_next = PH_PKTHDR;
                        end
                    end
                    pixels_left_next   = pixels_after;
                    byte_in_pixel_next = 2'd0;
                    if (emit_last) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    // Build the result transaction
    always_comb begin
        res              = '0;
        res.kind         = emit ? trpd_pkg::KIND_PIXEL
                         : (hdr_done ? trpd_pkg::KIND_HEADER : trpd_pkg::KIND_ERROR);
        res.frame_width  = width_next;
        res.frame_height = height_next;
        res.top_origin   = origin_next;
        if (emit) begin
            res.red        = asm_new[23:16];
            res.green      = asm_new[15:8];
            res.blue       = asm_new[7:0];
            res.alpha      = four_cur ? asm_new[31:24] : trpd_pkg::ALPHA_OPAQUE;
            res.repeat_res = emit_count;
            res.last_pixel = emit_last;
        end
    end

    assign res_valid = in_valid && (emit || hdr_done || fmt_err);

    // Hold state; advance on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= '0;
            id_skip_left_reg  <= '0;
            image_kind_reg    <= '0;
            width_reg         <= '0;
            height_reg        <= '0;
            depth_reg         <= '0;
            four_comp_reg     <= 1'b0;
            origin_reg        <= 1'b0;
            pixels_left_reg   <= '0;
            packet_left_reg   <= '0;
            byte_in_pixel_reg <= '0;
            pixel_asm_reg     <= '0;
        end else if (in_valid) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            id_skip_left_reg  <= id_skip_left_next;
            image_kind_reg    <= image_kind_next;
            width_reg         <= width_next;
            height_reg        <= height_next;
            depth_reg         <= depth_next;
            four_comp_reg     <= four_comp_next;
            origin_reg        <= origin_next;
            pixels_left_reg   <= pixels_left_next;
            packet_left_reg   <= packet_left_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            pixel_asm_reg     <= pixel_asm_next;
        end
    end

`ifndef SYNTHESIS
    a_last_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.last_pixel |=> phase_reg == PH_IDLE)
        else $error("image end did not idle the parser");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == trpd_pkg::KIND_PIXEL) |-> res.repeat_res != 8'd0)
        else $error("pixel run with zero repeat");

    a_area_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == trpd_pkg::KIND_HEADER)
        |=> pixels_left_reg == (32'($past(width_reg)) * 32'($past(height_reg))))
        else $error("pixel counter not loaded with image area");
`endif

endmodule

`default_nettype wire

### hw/rtl/trpd_out_buf.sv
// ----------------------------------------------------------------------------
// trpd_out_buf
// Output register with skid stage; ready depends on registers only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trpd_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire trpd_pkg::result_t push_data,
    output      logic              space,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      trpd_pkg::result_t m_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    trpd_pkg::result_t out_reg;
    trpd_pkg::result_t skid_reg;
    logic              pop;

    assign space   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign pop     = out_valid_reg && m_ready;

    // Refill the output register from skid first, else from the new transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push_valid;
            end
        end else if (push_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= push_data;
            end
        end else if (push_valid) begin
            skid_reg <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !skid_valid_reg)
        else $error("result pushed into full buffer");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output transaction changed while stalled");
`endif

endmodule

`default_nettype wire

### dv/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Streams TGA files into the decoder byte by byte: first a fixed 1x1 RLE file
// from reset, then random files (RLE, uncompressed, bad formats, empty and cut
// off images, noise). A behavioral decoder in the bench predicts every result
// transaction, and the result channel is checked field by field against it.
// Both channels idle at random, and the result side holds off once for long
// enough to back the decoder up into its input.
// ----------------------------------------------------------------------------

module tga_rle_pixel_decoder_tb;

    localparam int LIVE_ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int HOLD_AT_RESULT   = 40;
    localparam int HOLD_CYCLES      = 300;
    localparam int PRINT_CAP        = 40;
    localparam int DIRECTED_COUNT   = 23;

    // Decoder parse phases
    typedef enum logic [2:0] {
        P_HEADER, P_ID_SKIP, P_PKT_HEAD, P_RUN_PIXEL, P_RAW_PIXEL, P_PLAIN_PIXEL, P_IDLE
    } parse_phase_t;

    // One directed byte, with an optional typed-in result
    typedef struct packed {
        logic [7:0]        data;
        logic              first;
        logic              pinned;
        trpd_pkg::result_t want;
    } step_row_t;

    localparam trpd_pkg::result_t NO_RESULT   = '0;
    localparam trpd_pkg::result_t HEADER_1X1  = '{trpd_pkg::KIND_HEADER, 8'h00, 8'h00,
                                                  8'h00, 8'h00, 8'd0,
                                                  16'd1, 16'd1, 1'b1, 1'b0};
    localparam trpd_pkg::result_t RUN_CLIPPED = '{trpd_pkg::KIND_PIXEL, 8'hFF, 8'h80,
                                                  8'h00, 8'hFF, 8'd1,
                                                  16'd1, 16'd1, 1'b1, 1'b1};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_tuser  = 1'b0;   // [0] first_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;           // red, green, blue, alpha, repeat_res,
                                    // frame_width, frame_height, top_origin, zero pad
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        m_tlast;           // last_pixel

    tga_rle_pixel_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Predicted decoder state
    parse_phase_t dec_phase;
    logic [4:0]   hdr_pos;
    logic [7:0]   skip_left;
    logic [7:0]   img_type;
    logic [7:0]   img_depth;
    logic [15:0]  img_width;
    logic [15:0]  img_height;
    logic         rgba_wide;
    logic         origin;
    logic [31:0]  pixels_due;
    logic [7:0]   pkt_left;
    logic         pkt_is_run;
    logic [1:0]   pix_byte;
    logic [31:0]  pix_word;

    trpd_pkg::result_t pending_results[$];
    int      mismatch_count = 0;
    int      checked_count  = 0;
    int      live_items     = 0;
    int      cycle_count    = 0;
    bit      sender_burst   = 1'b0;
    bit      hold_done      = 1'b0;

    step_row_t directed_rows [DIRECTED_COUNT];

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------

    task automatic clear_decoder();
        dec_phase  = P_HEADER;
        hdr_pos    = '0;
        skip_left  = '0;
        img_type   = '0;
        img_depth  = '0;
        img_width  = '0;
        img_height = '0;
        rgba_wide  = 1'b0;
        origin     = 1'b0;
        pixels_due = '0;
        pkt_left   = '0;
        pkt_is_run = 1'b0;
        pix_byte   = '0;
        pix_word   = '0;
    endtask

    task automatic push_result(input trpd_pkg::kind_t k, input logic [31:0] rgba,
                               input logic [7:0] rep, input logic last);
        trpd_pkg::result_t r;
        r.kind         = k;
        r.red          = rgba[23:16];
        r.green        = rgba[15:8];
        r.blue         = rgba[7:0];
        r.alpha        = rgba[31:24];
        r.repeat_res   = rep;
        r.frame_width  = img_width;
        r.frame_height = img_height;
        r.top_origin   = origin;
        r.last_pixel   = last;
        pending_results.push_back(r);
    endtask

    task automatic enter_pixels();
        if (pixels_due == 0)
            dec_phase = P_IDLE;
        else if (img_type == trpd_pkg::TYPE_RLE)
            dec_phase = P_PKT_HEAD;
        else
            dec_phase = P_PLAIN_PIXEL;
    endtask

    // Store one color byte; true once the pixel is whole
    function automatic bit take_color(input logic [7:0] b);
        int pos;
        pos = pix_byte;
        pix_word[8*pos +: 8] = b;
        pix_byte = pix_byte + 2'd1;
        return (pos + 1) >= (rgba_wide ? 4 : 3);
    endfunction

    // Emit the assembled pixel, clipped to the pixels still owed
    task automatic emit_pixels(input logic [31:0] count);
        logic [31:0] rgba;
        logic        last;
        rgba = pix_word;
        if (!rgba_wide)
            rgba[31:24] = trpd_pkg::ALPHA_OPAQUE;
        if (count > pixels_due)
            count = pixels_due;
        pixels_due = pixels_due - count;
        last = (pixels_due == 0);
        push_result(trpd_pkg::KIND_PIXEL, rgba, count[7:0], last);
        pix_byte = '0;
        if (last)
            dec_phase = P_IDLE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first, output bit live);
        if (first)
            clear_decoder();
        live = (dec_phase != P_IDLE);
        case (dec_phase)
            P_HEADER: begin
                case (hdr_pos)
                    trpd_pkg::HDR_ID_LEN:    skip_left = b;
                    trpd_pkg::HDR_TYPE:      img_type = b;
                    trpd_pkg::HDR_WIDTH_LO:  img_width[7:0] = b;
                    trpd_pkg::HDR_WIDTH_HI:  img_width[15:8] = b;
                    trpd_pkg::HDR_HEIGHT_LO: img_height[7:0] = b;
                    trpd_pkg::HDR_HEIGHT_HI: img_height[15:8] = b;
                    trpd_pkg::HDR_DEPTH:     img_depth = b;
                    trpd_pkg::HDR_DESC:      origin = b[trpd_pkg::DESC_ORIGIN_BIT];
                    default: ;
                endcase
                if (hdr_pos < trpd_pkg::HDR_DESC) begin
                    hdr_pos = hdr_pos + 5'd1;
                end else begin
                    hdr_pos = '0;
                    if ((img_depth != trpd_pkg::DEPTH_24 && img_depth != trpd_pkg::DEPTH_32) ||
                        (img_type != trpd_pkg::TYPE_TRUECOLOR &&
                         img_type != trpd_pkg::TYPE_RLE)) begin
                        dec_phase = P_IDLE;
                        push_result(trpd_pkg::KIND_ERROR, '0, '0, 1'b0);
                    end else begin
                        rgba_wide  = (img_depth == trpd_pkg::DEPTH_32);
                        pixels_due = {16'd0, img_width} * {16'd0, img_height};
                        pix_byte   = '0;
                        if (skip_left != 0)
                            dec_phase = P_ID_SKIP;
                        else
                            enter_pixels();
                        push_result(trpd_pkg::KIND_HEADER, '0, '0, 1'b0);
                    end
                end
            end
            P_ID_SKIP: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 0)
                    enter_pixels();
            end
            P_PKT_HEAD: begin
                pkt_is_run = b[trpd_pkg::PKT_RUN_BIT];
                pkt_left   = {1'b0, b[6:0]} + 8'd1;
                pix_byte   = '0;
                dec_phase  = pkt_is_run ? P_RUN_PIXEL : P_RAW_PIXEL;
            end
            P_RUN_PIXEL: begin
                if (take_color(b)) begin
                    dec_phase = P_PKT_HEAD;
                    emit_pixels({24'd0, pkt_left});
                end
            end
            P_RAW_PIXEL: begin
                if (take_color(b)) begin
                    pkt_left = pkt_left - 8'd1;
                    if (pkt_left == 0)
                        dec_phase = P_PKT_HEAD;
                    emit_pixels(32'd1);
                end
            end
            P_PLAIN_PIXEL: begin
                if (take_color(b))
                    emit_pixels(32'd1);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one byte, wait for its transaction, then predict its result
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        bit live;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, first, live);
        if (live)
            live_items++;
    endtask

    // Send a pixel stream byte unless a cut-off file has used up its budget
    task automatic put_data(inout int budget, input logic [7:0] b);
        if (budget != 0) begin
            send_byte(b, 1'b0);
            if (budget > 0)
                budget--;
        end
    endtask

    task automatic send_file();
        logic [7:0] hdr [18];
        logic [6:0] cnt;
        logic       run;
        int variant, bpp, budget, owed, n;
        bit bad;

        sender_burst = ($urandom_range(0, 3) == 0);
        variant = $urandom_range(0, 19);

        // Drop in loose bytes, first_byte now and then
        if (variant < 2) begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            return;
        end

        foreach (hdr[i])
            hdr[i] = 8'($urandom_range(0, 255));
        bad = (variant < 4);
        hdr[trpd_pkg::HDR_ID_LEN] = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(4, 255))
                                                                  : 8'($urandom_range(0, 3));
        hdr[trpd_pkg::HDR_TYPE]  = $urandom_range(0, 1) ? trpd_pkg::TYPE_RLE
                                                        : trpd_pkg::TYPE_TRUECOLOR;
        hdr[trpd_pkg::HDR_DEPTH] = $urandom_range(0, 1) ? trpd_pkg::DEPTH_32
                                                        : trpd_pkg::DEPTH_24;
        if (bad) begin
            n = $urandom_range(0, 2);
            if (n != 1) begin
                hdr[trpd_pkg::HDR_TYPE] = 8'($urandom_range(0, 255));
                if (hdr[trpd_pkg::HDR_TYPE] == trpd_pkg::TYPE_RLE ||
                    hdr[trpd_pkg::HDR_TYPE] == trpd_pkg::TYPE_TRUECOLOR)
                    hdr[trpd_pkg::HDR_TYPE] = 8'd3;
            end
            if (n != 0) begin
                hdr[trpd_pkg::HDR_DEPTH] = 8'($urandom_range(0, 255));
                if (hdr[trpd_pkg::HDR_DEPTH] == trpd_pkg::DEPTH_24 ||
                    hdr[trpd_pkg::HDR_DEPTH] == trpd_pkg::DEPTH_32)
                    hdr[trpd_pkg::HDR_DEPTH] = 8'd16;
            end
        end

        // Mostly small images; sometimes an empty one at the size extremes
        if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1)) begin
                {hdr[trpd_pkg::HDR_WIDTH_HI], hdr[trpd_pkg::HDR_WIDTH_LO]}   = 16'hFFFF;
                {hdr[trpd_pkg::HDR_HEIGHT_HI], hdr[trpd_pkg::HDR_HEIGHT_LO]} = 16'h0000;
            end else begin
                {hdr[trpd_pkg::HDR_WIDTH_HI], hdr[trpd_pkg::HDR_WIDTH_LO]} = 16'h0000;
            end
        end else begin
            {hdr[trpd_pkg::HDR_WIDTH_HI], hdr[trpd_pkg::HDR_WIDTH_LO]} =
                16'($urandom_range(1, 6));
            {hdr[trpd_pkg::HDR_HEIGHT_HI], hdr[trpd_pkg::HDR_HEIGHT_LO]} =
                16'($urandom_range(1, 4));
        end

        foreach (hdr[i])
            send_byte(hdr[i], i == 0 && $urandom_range(0, 14) != 0);
        for (int i = 0; i < hdr[trpd_pkg::HDR_ID_LEN]; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);

        bpp    = (hdr[trpd_pkg::HDR_DEPTH] == trpd_pkg::DEPTH_32) ? 4 : 3;
        owed   = {hdr[trpd_pkg::HDR_WIDTH_HI], hdr[trpd_pkg::HDR_WIDTH_LO]} *
                 {hdr[trpd_pkg::HDR_HEIGHT_HI], hdr[trpd_pkg::HDR_HEIGHT_LO]};
        budget = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 12) : -1;

        if (!bad && owed > 0) begin
            if (hdr[trpd_pkg::HDR_TYPE] == trpd_pkg::TYPE_RLE) begin
                // Packets until the image is covered, runs may overshoot the end
                while (owed > 0 && budget != 0) begin
                    run = 1'($urandom_range(0, 1));
                    if (run && $urandom_range(0, 9) == 0)
                        cnt = 7'($urandom_range(8, 127));
                    else if ($urandom_range(0, 9) == 0)
                        cnt = 7'($urandom_range(8, 20));
                    else
                        cnt = 7'($urandom_range(0, 7));
                    put_data(budget, {run, cnt});
                    n = run ? bpp : (cnt + 1) * bpp;
                    repeat (n) put_data(budget, 8'($urandom_range(0, 255)));
                    owed -= cnt + 1;
                end
            end else begin
                repeat (owed * bpp) put_data(budget, 8'($urandom_range(0, 255)));
            end
        end

        // Trailing bytes land in idle and are dropped
        if (budget != 0) begin
            n = $urandom_range(0, 2);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns result %0d %s: got %0h, expected %0h",
                     $realtime, checked_count, what, got, want);
        mismatch_count++;
    endtask

    initial begin : result_sink
        int                stall;
        trpd_pkg::result_t got;
        trpd_pkg::result_t want;

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            // Hold off once for long enough to stall the input side
            if (checked_count == HOLD_AT_RESULT && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = ((checked_count % 64) < 16) ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);

            got.kind         = trpd_pkg::kind_t'(m_tuser);
            got.red          = m_tdata[7:0];
            got.green        = m_tdata[15:8];
            got.blue         = m_tdata[23:16];
            got.alpha        = m_tdata[31:24];
            got.repeat_res   = m_tdata[39:32];
            got.frame_width  = m_tdata[55:40];
            got.frame_height = m_tdata[71:56];
            got.top_origin   = m_tdata[72];
            got.last_pixel   = m_tlast;

            // Compare against the oldest expectation
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction, kind", 32'(got.kind), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.red != want.red)
                    report_mismatch("red", 32'(got.red), 32'(want.red));
                if (got.green != want.green)
                    report_mismatch("green", 32'(got.green), 32'(want.green));
                if (got.blue != want.blue)
                    report_mismatch("blue", 32'(got.blue), 32'(want.blue));
                if (got.alpha != want.alpha)
                    report_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
                if (got.repeat_res != want.repeat_res)
                    report_mismatch("repeat_res", 32'(got.repeat_res),
                                    32'(want.repeat_res));
                if (got.frame_width != want.frame_width)
                    report_mismatch("frame_width", 32'(got.frame_width),
                                    32'(want.frame_width));
                if (got.frame_height != want.frame_height)
                    report_mismatch("frame_height", 32'(got.frame_height),
                                    32'(want.frame_height));
                if (got.top_origin != want.top_origin)
                    report_mismatch("top_origin", 32'(got.top_origin),
                                    32'(want.top_origin));
                if (got.last_pixel != want.last_pixel)
                    report_mismatch("last_pixel", 32'(got.last_pixel),
                                    32'(want.last_pixel));
            end
            checked_count++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tga_rle_pixel_decoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : main_flow
        int before_size;

        // 1x1 RLE image, 24 bit, bottom-up flag clear, no first_byte after reset;
        // the 128-pixel run is clipped to one pixel and the byte after it is dropped
        directed_rows = '{
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h0A, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'h01, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h01, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h18, 1'b0, 1'b0, NO_RESULT},
            '{8'h20, 1'b0, 1'b1, HEADER_1X1},
            '{8'hFF, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b0, NO_RESULT},
            '{8'h80, 1'b0, 1'b0, NO_RESULT},
            '{8'hFF, 1'b0, 1'b1, RUN_CLIPPED},
            '{8'h5A, 1'b0, 1'b0, NO_RESULT}
        };

        clear_decoder();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; typed-in results replace the prediction
        foreach (directed_rows[i]) begin
            before_size = pending_results.size();
            send_byte(directed_rows[i].data, directed_rows[i].first);
            if (directed_rows[i].pinned && pending_results.size() > before_size)
                pending_results[$] = directed_rows[i].want;
        end

        // Random files until enough bytes have been decoded
        while (live_items < LIVE_ITEM_TARGET)
            send_file();
        s_tvalid <= 1'b0;

        // Drain, then idle so that any extra result can still show
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tga_rle_pixel_decoder: match");
        end else begin
            $display("tga_rle_pixel_decoder: mismatch");
        end
        $finish;
    end

endmodule
